// ===== hdl/rcfgg_pkg.sv =====
package rcfgg_pkg;

	localparam int CMD_W       = 4;
	localparam int STEP_W      = 12;
	localparam int FRAME_W     = 32;
	localparam int REASON_W    = 2;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 32;

	localparam int HEAP_WIDTH_DEF = 24;
	localparam int TIME_WIDTH_DEF = 20;

	localparam int RUNTIME_LIMIT_RST = 300000;
	localparam int HEAP_FLOOR_RST    = 8192;
	localparam int HEAP_TOL_RST      = 4096;
	localparam int STEP_CAP_RST      = 3600;

	localparam logic [CMD_W-1:0] CMD_TICK      = 4'd0;
	localparam logic [CMD_W-1:0] CMD_BEGIN     = 4'd1;
	localparam logic [CMD_W-1:0] CMD_END       = 4'd2;
	localparam logic [CMD_W-1:0] CMD_UNLIMITED = 4'd3;
	localparam logic [CMD_W-1:0] CMD_PAUSE     = 4'd4;
	localparam logic [CMD_W-1:0] CMD_RESUME    = 4'd5;
	localparam logic [CMD_W-1:0] CMD_STEP      = 4'd6;
	localparam logic [CMD_W-1:0] CMD_KEEPALIVE = 4'd7;
	localparam logic [CMD_W-1:0] CMD_PING      = 4'd8;
	localparam logic [CMD_W-1:0] CMD_FAIL      = 4'd9;

	localparam logic [CFG_IDX_W-1:0] REG_RUNTIME_LIMIT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_FLOOR    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_TOL      = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_CAP      = 4'd3;

	localparam logic [REASON_W-1:0] REASON_NONE    = 2'd0;
	localparam logic [REASON_W-1:0] REASON_RUNTIME = 2'd1;
	localparam logic [REASON_W-1:0] REASON_HEAP    = 2'd2;

	typedef struct packed {
		logic                ok;
		logic                go_home;
		logic [REASON_W-1:0] stop_reason;
		logic                held;
		logic                is_attached;
		logic                is_paused;
		logic [FRAME_W-1:0]  frame_count;
		logic [STEP_W-1:0]   step_backlog;
	} res_t;

endpackage

// ===== hdl/rcfgg_regs.sv =====
module rcfgg_regs
	import rcfgg_pkg::*;
#(
	parameter int HEAP_WIDTH = HEAP_WIDTH_DEF,
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output logic [TIME_WIDTH-1:0] runtime_limit,
	output logic [HEAP_WIDTH-1:0] heap_floor,
	output logic [HEAP_WIDTH-1:0] heap_tol,
	output logic [STEP_W-1:0]     step_cap
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runtime_limit <= TIME_WIDTH'(RUNTIME_LIMIT_RST);
			heap_floor    <= HEAP_WIDTH'(HEAP_FLOOR_RST);
			heap_tol      <= HEAP_WIDTH'(HEAP_TOL_RST);
			step_cap      <= STEP_W'(STEP_CAP_RST);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RUNTIME_LIMIT: runtime_limit <= wr_data[TIME_WIDTH-1:0];
				REG_HEAP_FLOOR:    heap_floor    <= wr_data[HEAP_WIDTH-1:0];
				REG_HEAP_TOL:      heap_tol      <= wr_data[HEAP_WIDTH-1:0];
				REG_STEP_CAP:      step_cap      <= wr_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/rcfgg_core.sv =====
module rcfgg_core
	import rcfgg_pkg::*;
#(
	parameter int HEAP_WIDTH = HEAP_WIDTH_DEF,
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [STEP_W-1:0]     step_frames,
	input  logic [HEAP_WIDTH-1:0] free_heap_bytes,
	input  logic                  view_active,
	input  logic [TIME_WIDTH-1:0] runtime_limit,
	input  logic [HEAP_WIDTH-1:0] heap_floor,
	input  logic [HEAP_WIDTH-1:0] heap_tol,
	input  logic [STEP_W-1:0]     step_cap,
	output res_t                  res
);

	logic                  attached_q, paused_q, unlimited_q, held_q;
	logic [STEP_W-1:0]     tokens_q;
	logic [FRAME_W-1:0]    frames_q;
	logic [TIME_WIDTH-1:0] elapsed_q;
	logic [HEAP_WIDTH-1:0] start_heap_q;

	logic                  attached_d, paused_d, unlimited_d, held_d;
	logic [STEP_W-1:0]     tokens_d;
	logic [FRAME_W-1:0]    frames_d;
	logic [TIME_WIDTH-1:0] elapsed_d;
	logic [HEAP_WIDTH-1:0] start_heap_d;

	logic                  ok, home;
	logic [REASON_W-1:0]   reason, stop;
	logic [STEP_W-1:0]     room, add;
	logic [HEAP_WIDTH:0]   heap_sum;

	always_comb begin
		heap_sum = {1'b0, free_heap_bytes} + {1'b0, heap_tol};
		priority if (!unlimited_q && elapsed_q >= runtime_limit) begin
			stop = REASON_RUNTIME;
		end else if (free_heap_bytes < heap_floor && heap_sum < {1'b0, start_heap_q}) begin
			stop = REASON_HEAP;
		end else begin
			stop = REASON_NONE;
		end
		room = (tokens_q < step_cap) ? step_cap - tokens_q : '0;
		add  = (step_frames < room) ? step_frames : room;
	end

	always_comb begin
		attached_d   = attached_q;
		paused_d     = paused_q;
		unlimited_d  = unlimited_q;
		held_d       = held_q;
		tokens_d     = tokens_q;
		frames_d     = frames_q;
		elapsed_d    = elapsed_q;
		start_heap_d = start_heap_q;
		ok           = 1'b0;
		home         = 1'b0;
		reason       = REASON_NONE;
		unique case (cmd)
			CMD_TICK: begin
				if (attached_q && !held_q && !(&elapsed_q))
					elapsed_d = elapsed_q + 1'b1;
				ok = 1'b1;
			end
			CMD_BEGIN: begin
				if (!attached_q) begin
					attached_d   = 1'b1;
					elapsed_d    = '0;
					start_heap_d = free_heap_bytes;
					unlimited_d  = 1'b0;
					paused_d     = 1'b0;
					tokens_d     = '0;
					frames_d     = '0;
					held_d       = 1'b0;
					ok           = 1'b1;
				end
			end
			CMD_END: begin
				if (attached_q) begin
					attached_d = 1'b0;
					paused_d   = 1'b0;
					tokens_d   = '0;
					held_d     = 1'b0;
					ok         = 1'b1;
				end
			end
			CMD_UNLIMITED: begin
				if (attached_q) begin
					unlimited_d = 1'b1;
					ok          = 1'b1;
				end
			end
			CMD_PAUSE: begin
				if (attached_q) begin
					paused_d = 1'b1;
					tokens_d = '0;
					ok       = 1'b1;
				end
			end
			CMD_RESUME: begin
				if (attached_q) begin
					paused_d = 1'b0;
					tokens_d = '0;
					held_d   = 1'b0;
					ok       = 1'b1;
				end
			end
			CMD_STEP: begin
				if (attached_q && step_frames != '0 && step_frames <= step_cap) begin
					paused_d = 1'b1;
					tokens_d = tokens_q + add;
					held_d   = 1'b0;
					ok       = 1'b1;
				end
			end
			CMD_KEEPALIVE: begin
				if (attached_q) begin
					reason = stop;
					if (stop != REASON_NONE) begin
						home = 1'b1;
					end else if (!paused_q || tokens_q != '0) begin
						if (paused_q)
							tokens_d = tokens_q - 1'b1;
						frames_d = frames_q + 1'b1;
						held_d   = 1'b0;
						ok       = 1'b1;
					end else begin
						held_d = view_active;
					end
				end
			end
			CMD_PING: begin
				if (!attached_q) begin
					ok = 1'b1;
				end else begin
					reason = stop;
					home   = (stop != REASON_NONE);
					ok     = (stop == REASON_NONE);
				end
			end
			CMD_FAIL: home = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attached_q   <= 1'b0;
			paused_q     <= 1'b0;
			unlimited_q  <= 1'b0;
			held_q       <= 1'b0;
			tokens_q     <= '0;
			frames_q     <= '0;
			elapsed_q    <= '0;
			start_heap_q <= '0;
		end else if (fire) begin
			attached_q   <= attached_d;
			paused_q     <= paused_d;
			unlimited_q  <= unlimited_d;
			held_q       <= held_d;
			tokens_q     <= tokens_d;
			frames_q     <= frames_d;
			elapsed_q    <= elapsed_d;
			start_heap_q <= start_heap_d;
		end
	end

	assign res = '{
		ok:            ok,
		go_home:       home,
		stop_reason:   reason,
		held:          held_d,
		is_attached:   attached_d,
		is_paused:     paused_d,
		frame_count:   frames_d,
		step_backlog:  tokens_d
	};

endmodule

// ===== hdl/run_control_frame_gate_guard.sv =====
// Run-control supervisor for one foreground task.
// Input channel (in_valid/in_ready): one command word per handshake, with
// step_frames, free_heap_bytes and view_active alongside cmd.
// Output channel (out_valid/out_ready): exactly one result word per command,
// in order, carrying the status after that command.
// Config channel (cfg_valid/cfg_ready): cfg_index selects runtime limit,
// heap floor, heap drop tolerance or step cap; cfg_ready is always high.
// Write config only while no command is in flight.
// Path: a command taken into the input register is evaluated against the
// core state and, once the result register is free or being read, its
// result lands in the result register and is offered on the output.
// Throughput: one command per cycle while out_ready stays high, set by the
// single state update per cycle in the core.
// Stall: while the receiver holds out_ready low the result waits and one
// more command sits in the input register; then in_ready drops.
// Reset: task detached, counters cleared, registers at their defaults,
// both channels empty.
module run_control_frame_gate_guard
	import rcfgg_pkg::*;
#(
	parameter int HEAP_WIDTH = HEAP_WIDTH_DEF,
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [STEP_W-1:0]     step_frames,
	input  logic [HEAP_WIDTH-1:0] free_heap_bytes,
	input  logic                  view_active,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  ok,
	output logic                  go_home,
	output logic [REASON_W-1:0]   stop_reason,
	output logic                  held,
	output logic                  is_attached,
	output logic                  is_paused,
	output logic [FRAME_W-1:0]    frame_count,
	output logic [STEP_W-1:0]     step_backlog,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                  valid_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [STEP_W-1:0]     frames_s1;
	logic [HEAP_WIDTH-1:0] heap_s1;
	logic                  view_s1;

	logic                  out_valid_q;
	res_t                  res_q;
	res_t                  res;
	logic                  fire;

	logic [TIME_WIDTH-1:0] runtime_limit;
	logic [HEAP_WIDTH-1:0] heap_floor, heap_tol;
	logic [STEP_W-1:0]     step_cap;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire;

	rcfgg_regs #(
		.HEAP_WIDTH(HEAP_WIDTH),
		.TIME_WIDTH(TIME_WIDTH)
	) u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (cfg_valid && cfg_ready),
		.wr_index     (cfg_index),
		.wr_data      (cfg_data),
		.runtime_limit(runtime_limit),
		.heap_floor   (heap_floor),
		.heap_tol     (heap_tol),
		.step_cap     (step_cap)
	);

	rcfgg_core #(
		.HEAP_WIDTH(HEAP_WIDTH),
		.TIME_WIDTH(TIME_WIDTH)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.cmd            (cmd_s1),
		.step_frames    (frames_s1),
		.free_heap_bytes(heap_s1),
		.view_active    (view_s1),
		.runtime_limit  (runtime_limit),
		.heap_floor     (heap_floor),
		.heap_tol       (heap_tol),
		.step_cap       (step_cap),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1    <= cmd;
			frames_s1 <= step_frames;
			heap_s1   <= free_heap_bytes;
			view_s1   <= view_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign ok            = res_q.ok;
	assign go_home       = res_q.go_home;
	assign stop_reason   = res_q.stop_reason;
	assign held          = res_q.held;
	assign is_attached   = res_q.is_attached;
	assign is_paused     = res_q.is_paused;
	assign frame_count   = res_q.frame_count;
	assign step_backlog  = res_q.step_backlog;

	a_home_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.ok && res_q.go_home))
		else $error("result asks for home and reports ok");

	a_reason_home: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.stop_reason != REASON_NONE |-> res_q.go_home)
		else $error("stop reason without home request");

	a_held_paused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.held || res_q.step_backlog != '0)
		|-> res_q.is_paused && res_q.is_attached)
		else $error("held or tokens outside attached pause");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a stalled output");

endmodule
